// ===== sv/wpcm_pkg.sv =====
// shared constants and types for the window peak counter
package wpcm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int MAX_LENGTH = 65536;
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 10;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int START_W    = IDX_W + 1;
    localparam int CHAIN_LEN  = MAX_WINDOW - 2;
    localparam int POS_W      = $clog2(CHAIN_LEN);
    localparam int MIN_WINDOW = 3;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // register index, taken from the word address bit
    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic             clr;
        logic             shift;
        logic             flag;
        logic [POS_W-1:0] ins_pos;
    } t_chain_ctrl;

endpackage

// ===== sv/window_peak_count_max_core.sv =====
// top level of the sliding-window peak counter
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  input     | i_in_valid / o_in_ready  | i_sample, i_last_sample
//  output    | o_out_valid / i_out_ready| o_piece_count, o_window_start
//  config    | psel/penable/pwrite      | paddr, pwdata, prdata (pready tied 1)
//
//  one sample per cycle; peak test, running count and best compare finish in
//  the cycle the sample is taken, the result lands in the output register
//  reset and every window_len write clear the sequence state and the whole
//  flag chain at once, so no clearing pass is needed
//  input stalls only while a result sits in the output register unread
module window_peak_count_max_core
    import wpcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LEN_W-1:0]    o_piece_count,
    output logic [START_W-1:0]  o_window_start
);

    logic [LEN_W-1:0]    r_win_len;
    logic [POS_W-1:0]    r_k_m1;
    logic [POS_W-1:0]    r_ins_pos;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] r_prev2;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_best;
    logic [IDX_W-1:0]    r_best_start;
    logic                r_out_valid;
    logic [LEN_W-1:0]    r_piece;
    logic [START_W-1:0]  r_start;

    logic [CNT_W-1:0]    n_cnt;
    logic [CNT_W-1:0]    n_best;
    logic [IDX_W-1:0]    n_best_start;

    logic                w_cfg_wr;
    logic [LEN_W-1:0]    w_wr_len;
    logic [LEN_W-1:0]    w_eff_len;
    logic                w_accept;
    logic                w_last;
    logic                w_peak;
    logic                w_drop;
    logic                w_complete;
    t_chain_ctrl         w_chain_ctrl;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
    assign w_wr_len = pwdata[LEN_W-1:0];

    always_comb begin
        priority if (w_wr_len < LEN_W'(MIN_WINDOW)) begin
            w_eff_len = LEN_W'(MIN_WINDOW);
        end else if (w_wr_len > LEN_W'(MAX_WINDOW)) begin
            w_eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_eff_len = w_wr_len;
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? DATA_W'(r_win_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= LEN_W'(MIN_WINDOW);
            r_k_m1    <= POS_W'(MIN_WINDOW - 1);
            r_ins_pos <= POS_W'(MAX_WINDOW - MIN_WINDOW);
        end else if (w_cfg_wr) begin
            r_win_len <= w_wr_len;
            r_k_m1    <= POS_W'(w_eff_len - LEN_W'(1));
            // entry cell so that a flag reaches the chain end after window_len-3 shifts
            r_ins_pos <= POS_W'(LEN_W'(MAX_WINDOW) - w_eff_len);
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = i_last_sample || (r_idx == IDX_W'(MAX_LENGTH - 1));

    // strict peak at the previous position, known once its right neighbor arrives
    assign w_peak = (r_idx >= IDX_W'(2)) && (r_prev > r_prev2) && (r_prev > i_sample);

    assign n_cnt      = r_cnt - CNT_W'(w_drop) + CNT_W'(w_peak);
    assign w_complete = (r_idx >= IDX_W'(r_k_m1));

    always_comb begin
        n_best       = r_best;
        n_best_start = r_best_start;
        if (w_complete && (n_cnt > r_best)) begin
            n_best       = n_cnt;
            n_best_start = r_idx - IDX_W'(r_k_m1);
        end
    end

    assign w_chain_ctrl.clr     = !i_rst_n || w_cfg_wr || (w_accept && w_last);
    assign w_chain_ctrl.shift   = w_accept;
    assign w_chain_ctrl.flag    = w_peak;
    assign w_chain_ctrl.ins_pos = r_ins_pos;

    wpcm_chain u_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_chain_ctrl),
        .o_drop_flag (w_drop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr || (w_accept && w_last)) begin
            r_prev       <= '0;
            r_prev2      <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_best       <= '0;
            r_best_start <= '0;
        end else if (w_accept) begin
            r_prev       <= i_sample;
            r_prev2      <= r_prev;
            r_idx        <= r_idx + IDX_W'(1);
            r_cnt        <= n_cnt;
            r_best       <= n_best;
            r_best_start <= n_best_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_piece <= LEN_W'(n_best) + LEN_W'(1);
            r_start <= START_W'(n_best_start) + START_W'(1);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_piece_count  = r_piece;
    assign o_window_start = r_start;

endmodule

// ===== sv/wpcm_cell.sv =====
// one peak-flag cell of the delay chain
module wpcm_cell
    import wpcm_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_sel,
    input  logic       i_ins_flag,
    input  logic       i_prev_flag,
    output logic       o_flag
);

    logic r_flag;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_flag <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_flag <= i_sel ? i_ins_flag : i_prev_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

// ===== sv/wpcm_chain.sv =====
// row of peak-flag cells; a flag enters at a window-dependent cell and leaves at the end
module wpcm_chain
    import wpcm_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    output logic        o_drop_flag
);

    logic [CHAIN_LEN-1:0] w_flag;
    t_cell_ctrl           w_cell_ctrl;

    assign w_cell_ctrl.clr   = i_ctrl.clr;
    assign w_cell_ctrl.shift = i_ctrl.shift;

    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
        logic w_prev;
        logic w_sel;

        if (g == 0) begin : g_head
            assign w_prev = 1'b0;
        end else begin : g_body
            assign w_prev = w_flag[g-1];
        end

        assign w_sel = (i_ctrl.ins_pos == POS_W'(g));

        wpcm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_cell_ctrl),
            .i_sel       (w_sel),
            .i_ins_flag  (i_ctrl.flag),
            .i_prev_flag (w_prev),
            .o_flag      (w_flag[g])
        );
    end

    // flag of the peak that just left the inside of the window
    assign o_drop_flag = w_flag[CHAIN_LEN-1];

endmodule

// ===== sv/wpcm_checker.sv =====
// port-level checks for the window peak counter, bound to the top level
module wpcm_checker
    import wpcm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [LEN_W-1:0]    o_piece_count,
    input logic [START_W-1:0]  o_window_start
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_piece_count) && $stable(o_window_start))
        else $error("result changed while stalled");

    // a full output register with a stalled sink blocks new requests
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result is stuck");

    // a new result only follows an accepted request
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without a request");

    // both result fields are one-based, and the piece count is at most MAX_WINDOW
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_piece_count != '0) && (o_window_start != '0)
            && (o_piece_count <= LEN_W'(MAX_WINDOW)))
        else $error("result out of range");

endmodule

bind window_peak_count_max_core wpcm_checker u_wpcm_checker (.*);
